// ===== sv/skmt_pkg.sv =====
// shared types, status codes and helpers of the sorted keyframe merge table
`timescale 1ns / 1ps

package skmt_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 64;

    // result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_READ_BAD = 3'd4;

    // operation codes
    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // component selector codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // one stored keyframe, time in the top bits
    typedef struct packed {
        logic [31:0]        key_time;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
    } t_entry;

    // one result item
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] position;
        t_entry     entry;
        logic [6:0] entry_count;
    } t_result;

    // write one component of an entry, selector three leaves it alone
    function automatic t_entry apply_comp(t_entry e, logic [1:0] comp,
                                          logic signed [31:0] value);
        t_entry r;
        r = e;
        unique case (comp)
            COMP_X:  r.val_x = value;
            COMP_Y:  r.val_y = value;
            COMP_Z:  r.val_z = value;
            default: r = e;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/sorted_keyframe_merge_table.sv =====
// top level: stream ports, default register, result register and store
//
//  channel  direction  handshake               payload
//  s        in         i_s_tvalid/o_s_tready   tdata key fields, tuser operation
//  m        out        o_m_tvalid/i_m_tready   tdata entry fields, tuser status
//  cfg      in         i_cfg_valid/o_cfg_ready default_value
//
// a read is served with one store read, none when the index is out of range; a merge reads
// each entry it scans, then reads and writes each entry it shifts up, all through the
// single store read port, whose data is registered
// reset clears the fill count and the default register; the store is not cleared
// a new request is taken once the previous result sits in the output register
`timescale 1ns / 1ps

module sorted_keyframe_merge_table
    import skmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // key_time, key_value, component, read_index
    input  logic [71:0]  i_s_tdata,
    // operation
    input  logic [0:0]   i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // position, entry_time, entry_x, entry_y, entry_z, entry_count
    output logic [143:0] o_m_tdata,
    // status
    output logic [2:0]   o_m_tuser,
    // default value register
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    logic signed [31:0] r_default;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_res_valid;
    logic               w_res_ready;
    t_result            w_res;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    t_entry             w_wdata;
    t_entry             w_rdata;

    // default value register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= '0;
        end else if (i_cfg_valid) begin
            r_default <= i_cfg_data;
        end
    end

    // result register
    assign w_res_ready = !r_out_valid || i_m_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {3'b000, r_out.entry_count, r_out.entry.val_z, r_out.entry.val_y,
                         r_out.entry.val_x, r_out.entry.key_time, r_out.position};

    skmt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_s_tvalid),
        .o_req_ready    (o_s_tready),
        .i_operation    (i_s_tuser[0]),
        .i_key_time     (i_s_tdata[31:0]),
        .i_key_value    (i_s_tdata[63:32]),
        .i_component    (i_s_tdata[65:64]),
        .i_read_index   (i_s_tdata[71:66]),
        .i_default_value(r_default),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata)
    );

    skmt_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

endmodule

// ===== sv/skmt_mem.sv =====
// keyframe store: one write port, one registered read port
`timescale 1ns / 1ps

module skmt_mem
    import skmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/skmt_ctrl.sv =====
// sequencer: scan, shift, insert, update and read-back over the keyframe store
`timescale 1ns / 1ps

module skmt_ctrl
    import skmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int CMPW = (CW > 6) ? CW : 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic               i_operation,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_value,
    input  logic [1:0]         i_component,
    input  logic [5:0]         i_read_index,
    input  logic signed [31:0] i_default_value,
    // result side
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    // store
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output t_entry             o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  t_entry             i_rdata
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_CHK    = 8'b0000_0100,
        S_SHRD   = 8'b0000_1000,
        S_SHWR   = 8'b0001_0000,
        S_NEW    = 8'b0010_0000,
        S_RDWAIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_idx, n_idx;
    logic [31:0]        r_time, n_time;
    logic signed [31:0] r_value, n_value;
    logic [1:0]         r_comp, n_comp;
    t_result            r_res, n_res;

    logic               w_full;
    logic               w_in_range;
    logic [CW-1:0]      w_idx_m1;
    t_entry             w_new;
    t_entry             w_upd;
    t_entry             w_zero;

    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_in_range = (CMPW'(i_read_index) < CMPW'(r_count));
    assign w_idx_m1   = r_idx - CW'(1);
    assign w_zero     = '0;
    assign w_new      = apply_comp('{key_time: r_time, val_x: i_default_value,
                                     val_y: i_default_value, val_z: i_default_value},
                                   r_comp, r_value);
    assign w_upd      = apply_comp(i_rdata, r_comp, r_value);

    // sequencer next state and store accesses
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_time  = r_time;
        n_value = r_value;
        n_comp  = r_comp;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_pos[AW-1:0];
        o_wdata = w_new;
        o_raddr = r_pos[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                o_raddr = AW'(i_read_index);
                if (i_req_valid) begin
                    n_time  = i_key_time;
                    n_value = i_key_value;
                    n_comp  = i_component;
                    n_pos   = '0;
                    if (i_operation == OP_READ) begin
                        n_res.status      = ST_READ_BAD;
                        n_res.position    = i_read_index;
                        n_res.entry       = w_zero;
                        n_res.entry_count = 7'(r_count);
                        n_state = w_in_range ? S_RDWAIT : S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            // issue a read of the entry under the scan pointer, or end the scan at the fill count
            S_SCAN: begin
                if (r_pos == r_count) begin
                    n_idx = r_count;
                    if (w_full) begin
                        n_res.status      = ST_FULL;
                        n_res.position    = '0;
                        n_res.entry       = w_zero;
                        n_res.entry_count = 7'(r_count);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHRD;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            // compare the stored time against the request
            S_CHK: begin
                if (i_rdata.key_time == r_time) begin
                    o_we              = 1'b1;
                    o_wdata           = w_upd;
                    n_res.status      = ST_UPDATED;
                    n_res.position    = 6'(r_pos);
                    n_res.entry       = w_upd;
                    n_res.entry_count = 7'(r_count);
                    n_state = S_DONE;
                end else if (i_rdata.key_time > r_time) begin
                    n_idx = r_count;
                    if (w_full) begin
                        n_res.status      = ST_FULL;
                        n_res.position    = '0;
                        n_res.entry       = w_zero;
                        n_res.entry_count = 7'(r_count);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHRD;
                    end
                end else begin
                    n_pos   = r_pos + CW'(1);
                    n_state = S_SCAN;
                end
            end
            // shift pass from the top down: read the entry below
            S_SHRD: begin
                o_raddr = w_idx_m1[AW-1:0];
                n_state = (r_idx == r_pos) ? S_NEW : S_SHWR;
            end
            // write it one place up
            S_SHWR: begin
                o_we    = 1'b1;
                o_waddr = r_idx[AW-1:0];
                o_wdata = i_rdata;
                n_idx   = w_idx_m1;
                n_state = S_SHRD;
            end
            // place the new keyframe in the gap
            S_NEW: begin
                o_we              = 1'b1;
                n_count           = r_count + CW'(1);
                n_res.status      = ST_INSERTED;
                n_res.position    = 6'(r_pos);
                n_res.entry       = w_new;
                n_res.entry_count = 7'(r_count + CW'(1));
                n_state = S_DONE;
            end
            S_RDWAIT: begin
                n_res.status = ST_READ_OK;
                n_res.entry  = i_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_time  <= n_time;
        r_value <= n_value;
        r_comp  <= n_comp;
        r_res   <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== bench/sorted_keyframe_merge_table_tb.sv =====
// self-checking bench for the sorted keyframe merge table: random and directed merge/read requests
`timescale 1ns / 1ps

module sorted_keyframe_merge_table_tb;
    import skmt_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 4 * DEPTH + 8;

    // selector value that writes no component
    localparam logic [1:0] COMP_SKIP = 2'd3;

    // one request as the bench sees it
    typedef struct {
        logic               op;
        logic [31:0]        key_time;
        logic signed [31:0] key_value;
        logic [1:0]         comp;
        logic [5:0]         read_index;
    } t_request;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [71:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [31:0]  cfg_data = '0;
    wire          o_s_tready;
    wire          o_m_tvalid;
    wire [143:0]  o_m_tdata;
    wire [2:0]    o_m_tuser;
    wire          o_cfg_ready;

    sorted_keyframe_merge_table #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // bench-side copy of the table and the default register
    t_entry             kf_table [DEPTH];
    int                 kf_held = 0;
    logic signed [31:0] kf_default = '0;

    t_request    pending_requests [$];
    t_result     expected_results [$];
    logic [31:0] used_times [$];
    t_request    cur_req;

    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int cycle_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int mismatch_count = 0;
    int cfg_writes = 0;
    int status_seen [5] = '{default: 0};

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // one step of the keyframe table: merge or read, returns the result item
    function automatic t_result table_step(t_request rq);
        t_result r;
        int      pos;
        bit      found;
        bit      done;
        int      i;
        r = '0;
        r.entry_count = kf_held[6:0];
        if (rq.op == OP_READ) begin
            r.position = rq.read_index;
            if (int'(rq.read_index) < kf_held) begin
                r.status = ST_READ_OK;
                r.entry  = kf_table[rq.read_index];
            end else begin
                r.status = ST_READ_BAD;
            end
            return r;
        end
        // scan for an equal time or the first larger one
        pos = 0;
        found = 1'b0;
        done = 1'b0;
        while (!done && pos < kf_held) begin
            if (kf_table[pos].key_time == rq.key_time) begin
                found = 1'b1;
                done = 1'b1;
            end else if (kf_table[pos].key_time > rq.key_time) begin
                done = 1'b1;
            end else begin
                pos++;
            end
        end
        if (found) begin
            r.status = ST_UPDATED;
        end else begin
            if (kf_held >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            // shift later keyframes up and open a fresh one
            for (i = kf_held; i > pos; i--)
                kf_table[i] = kf_table[i - 1];
            kf_table[pos].key_time = rq.key_time;
            kf_table[pos].val_x = kf_default;
            kf_table[pos].val_y = kf_default;
            kf_table[pos].val_z = kf_default;
            kf_held++;
            r.status = ST_INSERTED;
        end
        // selector three writes nothing
        case (rq.comp)
            COMP_X: kf_table[pos].val_x = rq.key_value;
            COMP_Y: kf_table[pos].val_y = rq.key_value;
            COMP_Z: kf_table[pos].val_z = rq.key_value;
            default: ;
        endcase
        r.position    = pos[5:0];
        r.entry       = kf_table[pos];
        r.entry_count = kf_held[6:0];
        return r;
    endfunction

    // request driver, fed from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                expected_results.push_back(table_step(cur_req));
                accepted_count++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                    cur_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.read_index, cur_req.comp, cur_req.key_value,
                                cur_req.key_time};
                    s_tuser <= cur_req.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // compare one result field against its expectation
    task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         checked_count, name, exp_val, act_val);
        end
    endtask

    // result monitor and checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: status %0d position %0d",
                                 o_m_tuser, o_m_tdata[5:0]);
                end else begin
                    exp_r = expected_results.pop_front();
                    report_field("status", 32'(exp_r.status), 32'(o_m_tuser));
                    report_field("position", 32'(exp_r.position), 32'(o_m_tdata[5:0]));
                    report_field("entry_time", exp_r.entry.key_time, o_m_tdata[37:6]);
                    report_field("entry_x", exp_r.entry.val_x, o_m_tdata[69:38]);
                    report_field("entry_y", exp_r.entry.val_y, o_m_tdata[101:70]);
                    report_field("entry_z", exp_r.entry.val_z, o_m_tdata[133:102]);
                    report_field("entry_count", 32'(exp_r.entry_count),
                                 32'(o_m_tdata[140:134]));
                    if (exp_r.status <= ST_READ_BAD)
                        status_seen[exp_r.status]++;
                    checked_count++;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_results.size());
            $display("sorted_keyframe_merge_table_tb: FAIL");
            $finish;
        end
    end

    task automatic add_merge(logic [31:0] t, logic [31:0] v, logic [1:0] comp);
        t_request rq;
        rq.op = OP_MERGE;
        rq.key_time = t;
        rq.key_value = v;
        rq.comp = comp;
        rq.read_index = '0;
        pending_requests.push_back(rq);
        used_times.push_back(t);
    endtask

    task automatic add_read(logic [5:0] idx);
        t_request rq;
        rq.op = OP_READ;
        rq.key_time = '0;
        rq.key_value = '0;
        rq.comp = '0;
        rq.read_index = idx;
        pending_requests.push_back(rq);
    endtask

    // random requests: mostly merges onto known times, a few new times and reads
    task automatic add_random(int n);
        t_request rq;
        int       k;
        int       pick;
        for (k = 0; k < n; k++) begin
            rq.op = OP_MERGE;
            rq.key_time = $urandom;
            rq.comp = 2'($urandom_range(0, 3));
            rq.read_index = 6'($urandom_range(0, 63));
            pick = $urandom_range(0, 7);
            if (pick == 0)
                rq.key_value = 32'h7FFF_FFFF;
            else if (pick == 1)
                rq.key_value = 32'h8000_0000;
            else
                rq.key_value = $urandom;
            if ($urandom_range(0, 99) < 15) begin
                rq.op = OP_READ;
            end else if (used_times.size() == 0 || $urandom_range(0, 99) < 8) begin
                // a fresh time, leaning towards the ends and small values
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    rq.key_time = '0;
                else if (pick == 1)
                    rq.key_time = 32'hFFFF_FFFF;
                else if (pick < 5)
                    rq.key_time = $urandom_range(0, 4095);
                used_times.push_back(rq.key_time);
            end else begin
                rq.key_time = used_times[$urandom_range(0, used_times.size() - 1)];
            end
            pending_requests.push_back(rq);
        end
    endtask

    // hold until every request is out and every result is back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_default(logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        kf_default = value;
        cfg_writes++;
    endtask

    // stimulus sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with the reset default
        s_idle_pct = 0;
        m_idle_pct = 0;
        add_read(6'd0);
        add_read(6'd63);
        add_merge(32'd1000, 32'h7FFF_FFFF, COMP_X);
        add_merge(32'd1000, 32'h8000_0000, COMP_Y);
        add_merge(32'd1000, 32'hFFFF_FFFF, COMP_Z);
        add_merge(32'd0, 32'd123, COMP_SKIP);
        add_merge(32'hFFFF_FFFF, 32'd0, COMP_X);
        add_merge(32'd500, 32'h0001_8000, COMP_Y);
        add_merge(32'hFFFF_FFFF, 32'h1234_5678, COMP_SKIP);
        add_merge(32'd0, 32'h8000_0000, COMP_Z);
        add_merge(32'd999, 32'h7FFF_FFFF, COMP_Z);
        add_merge(32'd1001, 32'h5555_AAAA, COMP_X);
        add_read(6'd0);
        add_read(6'd1);
        add_read(6'd3);
        add_read(6'd6);
        add_read(6'd7);
        add_read(6'd63);
        wait_drained();

        // biased sender-light, receiver-heavy idling, two default settings
        s_idle_pct = 11;
        m_idle_pct = 56;
        write_default(32'h7FFF_FFFF);
        add_random(290);
        wait_drained();
        write_default(32'h8000_0000);
        add_random(290);
        wait_drained();

        // the other way round
        s_idle_pct = 56;
        m_idle_pct = 11;
        write_default($urandom);
        add_random(290);
        wait_drained();
        write_default(32'h0000_0000);
        add_random(290);
        wait_drained();

        // no idling at all
        s_idle_pct = 0;
        m_idle_pct = 0;
        write_default($urandom);
        add_random(290);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d requests over %0d default settings, table ended with %0d keyframes",
                 accepted_count, cfg_writes, kf_held);
        $display("results: %0d updated, %0d inserted, %0d dropped full, %0d read, %0d read bad",
                 status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_READ_OK], status_seen[ST_READ_BAD]);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("sorted_keyframe_merge_table_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     mismatch_count, expected_results.size());
            $display("sorted_keyframe_merge_table_tb: FAIL");
        end
        $finish;
    end

endmodule
